>>> hw/rtl/bmsort_pkg.sv
// Shared constants, types and sequencer states for the bottom-up merge sorter.
package bmsort_pkg;

    // Store depth and the derived address and count widths.
    localparam int DEPTH  = 64;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef logic [CW-1:0]     t_cnt;
    typedef logic [CW:0]       t_sum;
    typedef logic [AW-1:0]     t_addr;
    typedef logic [DATA_W-1:0] t_data;

    typedef enum logic [3:0] {
        S_LOAD,
        S_RUN_START,
        S_RD_L,
        S_RD_R,
        S_CAP_R,
        S_MERGE,
        S_REFILL,
        S_EMIT_RD,
        S_EMIT_CAP
    } t_state;

endpackage

>>> hw/rtl/bmsort_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module bmsort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> hw/rtl/bottom_up_merge_sorter.sv
// Bottom-up merge sorter: collects up to DEPTH unsigned 32-bit values, sorts them
// ascending and streams them back out. Beats arrive on the input channel one per
// cycle while the block is loading; a beat with last set closes the set, and beats
// beyond DEPTH are dropped (a dropped beat with last still closes the set). The
// set is then sorted by merge passes whose run width doubles each pass, ping-ponging
// between two RAMs (element_store and merge_scratch), each with a registered read.
// Each merged element takes a compare-and-write (S_MERGE), then a refill of the run
// head that was taken (S_REFILL), except the last element of a run, which needs no
// refill. Each run starts with the setup states S_RUN_START, S_RD_L, S_RD_R and
// S_CAP_R, and ceil(log2 n) passes are made over n elements. Emission then handles
// each result beat in turn, waiting while the output stalls: a read, a capture into
// the output register, and a wait in which the previous beat leaves that register
// before the next read starts. The input is stalled from the last beat of a set
// until the final result has been read from RAM into the output register; loading
// of the next set may proceed while that final beat waits.
module bottom_up_merge_sorter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [bmsort_pkg::DATA_W-1:0]  i_value,
    input  logic                           i_last,
    // Result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [bmsort_pkg::DATA_W-1:0]  o_sorted_value,
    output logic                           o_final_res
);

    import bmsort_pkg::*;

    // Sequencer state and control registers.
    t_state r_state, n_state;
    t_cnt   r_count, n_count;   // elements in the current set
    t_cnt   r_w,     n_w;       // current run width
    t_cnt   r_base,  n_base;    // start of the current pair of runs
    t_cnt   r_lp,    n_lp;      // next left-run element
    t_cnt   r_le,    n_le;      // end (exclusive) of left run
    t_cnt   r_rp,    n_rp;      // next right-run element
    t_cnt   r_re,    n_re;      // end (exclusive) of right run
    t_cnt   r_k,     n_k;       // destination index
    t_cnt   r_idx,   n_idx;     // emission index
    logic   r_src,   n_src;     // which RAM holds the current data
    logic   r_took_right, n_took_right;
    logic   r_out_valid,  n_out_valid;

    // Payload registers: run heads and the output register.
    t_data  r_lv, r_rv;
    t_data  r_out_value;
    logic   r_out_final;

    // RAM ports.
    logic   we0, we1;
    t_addr  waddr, raddr;
    t_data  wdata, rdata0, rdata1, rdata;

    logic   in_acc, out_acc;
    logic   store_ok, left_ok, right_ok, take_right;
    logic   run_last, pass_done, sort_done, idx_last;
    t_cnt   cnt_inc, set_n, lp_inc, rp_inc, le_calc, re_calc;
    t_sum   n_ext, sum_bw, sum_b2w, k_inc, w_dbl;

    bmsort_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_element_store (
        .i_clk   (i_clk),
        .i_we    (we0),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata0)
    );

    bmsort_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_merge_scratch (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata1)
    );

    // Both RAMs are read at the same address; the source side is selected here.
    // A merge always reads one RAM and writes the other, so no read can hit an
    // entry that is being written in the same pass.
    assign rdata = r_src ? rdata1 : rdata0;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = r_out_valid && !i_out_stall;

    // Load bookkeeping.
    assign store_ok = r_count < t_cnt'(DEPTH);
    assign cnt_inc  = r_count + t_cnt'(1);
    assign set_n    = store_ok ? cnt_inc : r_count;

    // Run bounds: left is [base, min(base+w, n)), right is [that, min(base+2w, n)).
    // When the right run is empty the merge simply copies the left run across.
    assign n_ext   = {1'b0, r_count};
    assign sum_bw  = {1'b0, r_base} + {1'b0, r_w};
    assign sum_b2w = sum_bw + {1'b0, r_w};
    assign le_calc = (sum_bw  < n_ext) ? sum_bw[CW-1:0]  : r_count;
    assign re_calc = (sum_b2w < n_ext) ? sum_b2w[CW-1:0] : r_count;

    // Merge decision; ties go to the left run.
    assign left_ok    = r_lp < r_le;
    assign right_ok   = r_rp < r_re;
    assign take_right = right_ok && (!left_ok || (r_rv < r_lv));
    assign lp_inc     = r_lp + t_cnt'(1);
    assign rp_inc     = r_rp + t_cnt'(1);
    assign k_inc      = {1'b0, r_k} + t_sum'(1);
    assign run_last   = k_inc == {1'b0, r_re};
    assign pass_done  = sum_b2w >= n_ext;
    assign w_dbl      = {r_w, 1'b0};
    assign sort_done  = w_dbl >= n_ext;
    assign idx_last   = ({1'b0, r_idx} + t_sum'(1)) == n_ext;

    // Next state, RAM controls and control register updates.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_w          = r_w;
        n_base       = r_base;
        n_lp         = r_lp;
        n_le         = r_le;
        n_rp         = r_rp;
        n_re         = r_re;
        n_k          = r_k;
        n_idx        = r_idx;
        n_src        = r_src;
        n_took_right = r_took_right;
        n_out_valid  = r_out_valid && !out_acc;
        we0          = 1'b0;
        we1          = 1'b0;
        waddr        = r_k[AW-1:0];
        wdata        = take_right ? r_rv : r_lv;
        raddr        = '0;
        o_in_stall   = 1'b1;

        unique case (r_state)
            S_LOAD: begin
                o_in_stall = 1'b0;
                waddr      = r_count[AW-1:0];
                wdata      = i_value;
                if (in_acc) begin
                    we0     = store_ok;
                    n_count = set_n;
                    if (i_last) begin
                        n_src  = 1'b0;
                        n_w    = t_cnt'(1);
                        n_base = '0;
                        n_idx  = '0;
                        // A single element is already sorted.
                        n_state = (set_n > t_cnt'(1)) ? S_RUN_START : S_EMIT_RD;
                    end
                end
            end
            S_RUN_START: begin
                n_lp    = r_base;
                n_le    = le_calc;
                n_rp    = le_calc;
                n_re    = re_calc;
                n_k     = r_base;
                n_state = S_RD_L;
            end
            S_RD_L: begin
                raddr   = r_lp[AW-1:0];
                n_state = S_RD_R;
            end
            S_RD_R: begin
                raddr   = r_rp[AW-1:0];
                n_state = S_CAP_R;
            end
            S_CAP_R: begin
                n_state = S_MERGE;
            end
            S_MERGE: begin
                we0          = r_src;
                we1          = !r_src;
                n_took_right = take_right;
                n_k          = k_inc[CW-1:0];
                if (take_right) begin
                    n_rp  = rp_inc;
                    raddr = rp_inc[AW-1:0];
                end else begin
                    n_lp  = lp_inc;
                    raddr = lp_inc[AW-1:0];
                end
                if (!run_last) begin
                    n_state = S_REFILL;
                end else if (!pass_done) begin
                    n_base  = sum_b2w[CW-1:0];
                    n_state = S_RUN_START;
                end else begin
                    // Pass complete: the destination becomes the source.
                    n_src  = !r_src;
                    n_w    = w_dbl[CW-1:0];
                    n_base = '0;
                    n_idx  = '0;
                    n_state = sort_done ? S_EMIT_RD : S_RUN_START;
                end
            end
            S_REFILL: begin
                n_state = S_MERGE;
            end
            S_EMIT_RD: begin
                raddr = r_idx[AW-1:0];
                if (!r_out_valid) begin
                    n_state = S_EMIT_CAP;
                end
            end
            S_EMIT_CAP: begin
                n_out_valid = 1'b1;
                if (idx_last) begin
                    n_count = '0;
                    n_state = S_LOAD;
                end else begin
                    n_idx   = r_idx + t_cnt'(1);
                    n_state = S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_count      <= '0;
            r_w          <= '0;
            r_base       <= '0;
            r_lp         <= '0;
            r_le         <= '0;
            r_rp         <= '0;
            r_re         <= '0;
            r_k          <= '0;
            r_idx        <= '0;
            r_src        <= 1'b0;
            r_took_right <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_w          <= n_w;
            r_base       <= n_base;
            r_lp         <= n_lp;
            r_le         <= n_le;
            r_rp         <= n_rp;
            r_re         <= n_re;
            r_k          <= n_k;
            r_idx        <= n_idx;
            r_src        <= n_src;
            r_took_right <= n_took_right;
            r_out_valid  <= n_out_valid;
        end
    end

    // Run heads and the output register are loaded from RAM read data in the cycle after the read is issued.
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD_R) begin
            r_lv <= rdata;
        end
        if (r_state == S_CAP_R) begin
            r_rv <= rdata;
        end
        if (r_state == S_REFILL) begin
            if (r_took_right) begin
                r_rv <= rdata;
            end else begin
                r_lv <= rdata;
            end
        end
        if (r_state == S_EMIT_CAP) begin
            r_out_value <= rdata;
            r_out_final <= idx_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_final_res    = r_out_final;

    // The destination index never runs past the set.
    a_k_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE) |-> (r_k < r_count))
        else $error("merge destination index beyond set size");

    // Run pointers stay inside their runs, so at least one side is always available.
    a_ptr_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE) |-> ((r_lp <= r_le) && (r_rp <= r_re) && (left_ok || right_ok)))
        else $error("merge run pointer out of bounds");

    // The element count never exceeds the store depth.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(DEPTH))
        else $error("element count exceeds store depth");

    // Capturing the final result returns the block to loading with an empty set.
    a_final_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT_CAP) && idx_last) |=>
            ((r_state == S_LOAD) && (r_count == '0) && r_out_valid && r_out_final))
        else $error("final result did not restart loading");

endmodule
